// ===== design/i2cbb_pkg.sv =====
// Shared types and constants for the tick-driven I2C bit-bang master.
package i2cbb_pkg;

  localparam int unsigned DLY_W  = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned BCNT_W = 4;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned CIDX_W = 3;

  // Command codes carried in the op field.
  localparam logic [OP_W-1:0] OP_START = 3'd0;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_ACK   = 3'd4;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_SHORT  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_MEDIUM = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_SETUP  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_LONG   = 3'd3;

  localparam logic [DLY_W-1:0] RST_SHORT  = 8'd2;
  localparam logic [DLY_W-1:0] RST_MEDIUM = 8'd6;
  localparam logic [DLY_W-1:0] RST_SETUP  = 8'd10;
  localparam logic [DLY_W-1:0] RST_LONG   = 8'd18;

  localparam logic [BCNT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [21:0] {
    PH_IDLE  = 22'h000001,
    PH_S0    = 22'h000002,
    PH_S1    = 22'h000004,
    PH_S2    = 22'h000008,
    PH_S3    = 22'h000010,
    PH_P0    = 22'h000020,
    PH_P1    = 22'h000040,
    PH_P2    = 22'h000080,
    PH_WBIT  = 22'h000100,
    PH_WHI   = 22'h000200,
    PH_WTAIL = 22'h000400,
    PH_WAREL = 22'h000800,
    PH_WAHI  = 22'h001000,
    PH_WALO  = 22'h002000,
    PH_R0    = 22'h004000,
    PH_RLO   = 22'h008000,
    PH_RHI   = 22'h010000,
    PH_RSMP  = 22'h020000,
    PH_REND  = 22'h040000,
    PH_A0    = 22'h080000,
    PH_A1    = 22'h100000,
    PH_A2    = 22'h200000
  } phase_t;

  typedef struct packed {
    logic [DLY_W-1:0] dly_short;
    logic [DLY_W-1:0] dly_medium;
    logic [DLY_W-1:0] dly_setup;
    logic [DLY_W-1:0] dly_long;
  } cfg_t;

  typedef struct packed {
    logic              cmd_valid;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] wr_data;
    logic              ack_level;
    logic              sda_in;
  } req_t;

  typedef struct packed {
    phase_t            phase;
    logic [DLY_W-1:0]  wait_count;
    logic [BCNT_W-1:0] bit_count;
    logic [BYTE_W-1:0] shift_reg;
    logic [OP_W-1:0]   current_op;
    logic              scl_level;
    logic              sda_level;
    logic              sda_dir;
    logic [BYTE_W-1:0] rx_byte;
  } mach_t;

  typedef struct packed {
    mach_t st;
    logic  done;
  } step_t;

endpackage

// ===== design/i2cbb_step.sv =====
// One tick of the I2C bit-bang sequencer: next bus state from current state and request.
module i2cbb_step
  import i2cbb_pkg::*;
(
  input  mach_t st,
  input  req_t  req,
  input  cfg_t  cfg,
  output step_t res
);

  // Sets the pin levels of a step on its first tick and loads its hold time.
  function automatic mach_t enter_step(mach_t s, phase_t p, logic sda_in, cfg_t c);
    mach_t t;
    t = s;
    t.phase = p;
    unique case (p)
      PH_S0:    begin t.sda_level = 1'b1; t.wait_count = c.dly_short;  end
      PH_S1:    begin t.scl_level = 1'b1; t.wait_count = c.dly_long;   end
      PH_S2:    begin t.sda_level = 1'b0; t.wait_count = c.dly_long;   end
      PH_S3:    begin t.scl_level = 1'b0; t.wait_count = c.dly_medium; end
      PH_P0:    begin t.sda_level = 1'b0; t.wait_count = c.dly_short;  end
      PH_P1:    begin t.scl_level = 1'b1; t.wait_count = c.dly_long;   end
      PH_P2:    begin t.sda_level = 1'b1; t.wait_count = c.dly_setup;  end
      PH_WBIT: begin
        // The first data bit follows start with SCL already low.
        if (s.bit_count != '0) t.scl_level = 1'b0;
        t.sda_level  = s.shift_reg[BYTE_W-1];
        t.shift_reg  = {s.shift_reg[BYTE_W-2:0], 1'b0};
        t.bit_count  = s.bit_count + 1'b1;
        t.wait_count = c.dly_short;
      end
      PH_WHI:   begin t.scl_level = 1'b1; t.wait_count = c.dly_long;   end
      PH_WTAIL: begin t.scl_level = 1'b0; t.wait_count = c.dly_medium; end
      PH_WAREL: begin t.sda_level = 1'b1; t.wait_count = c.dly_medium; end
      PH_WAHI:  begin t.scl_level = 1'b1; t.wait_count = c.dly_long;   end
      PH_WALO:  begin t.scl_level = 1'b0; t.wait_count = c.dly_medium; end
      PH_R0: begin
        t.sda_level  = 1'b1;
        t.sda_dir    = 1'b0;
        t.wait_count = c.dly_short;
      end
      PH_RLO:   begin t.scl_level = 1'b0; t.wait_count = c.dly_long;   end
      PH_RHI:   begin t.scl_level = 1'b1; t.wait_count = c.dly_short;  end
      PH_RSMP: begin
        t.shift_reg  = {s.shift_reg[BYTE_W-2:0], sda_in};
        t.bit_count  = s.bit_count + 1'b1;
        t.wait_count = c.dly_short;
      end
      PH_REND:  begin t.scl_level = 1'b0; t.wait_count = c.dly_medium; end
      PH_A0:    begin t.sda_level = s.shift_reg[0]; t.wait_count = c.dly_setup; end
      PH_A1:    begin t.scl_level = 1'b1; t.wait_count = c.dly_long;   end
      PH_A2:    begin t.scl_level = 1'b0; t.wait_count = c.dly_medium; end
      default:  begin t.phase = PH_IDLE; t.wait_count = '0; end
    endcase
    return t;
  endfunction

  function automatic phase_t next_phase(phase_t p, logic [BCNT_W-1:0] bits);
    phase_t n;
    unique case (p)
      PH_S0:    n = PH_S1;
      PH_S1:    n = PH_S2;
      PH_S2:    n = PH_S3;
      PH_P0:    n = PH_P1;
      PH_P1:    n = PH_P2;
      PH_WBIT:  n = PH_WHI;
      PH_WHI:   n = (bits < BITS_PER_BYTE) ? PH_WBIT : PH_WTAIL;
      PH_WTAIL: n = PH_WAREL;
      PH_WAREL: n = PH_WAHI;
      PH_WAHI:  n = PH_WALO;
      PH_R0:    n = PH_RLO;
      PH_RLO:   n = PH_RHI;
      PH_RHI:   n = PH_RSMP;
      PH_RSMP:  n = (bits < BITS_PER_BYTE) ? PH_RLO : PH_REND;
      PH_A0:    n = PH_A1;
      PH_A1:    n = PH_A2;
      default:  n = PH_IDLE;
    endcase
    return n;
  endfunction

  mach_t  base;
  phase_t nx;

  always_comb begin
    base = st;
    nx   = next_phase(st.phase, st.bit_count);
    res.st   = st;
    res.done = 1'b0;
    if (st.phase == PH_IDLE) begin
      // Unknown op codes are dropped and the sequencer stays idle.
      if (req.cmd_valid && (req.op <= OP_ACK)) begin
        base.current_op = req.op;
        base.bit_count  = '0;
        base.shift_reg  = '0;
        unique case (req.op)
          OP_START: res.st = enter_step(base, PH_S0, req.sda_in, cfg);
          OP_STOP:  res.st = enter_step(base, PH_P0, req.sda_in, cfg);
          OP_WRITE: begin
            base.shift_reg = req.wr_data;
            res.st = enter_step(base, PH_WBIT, req.sda_in, cfg);
          end
          OP_READ:  res.st = enter_step(base, PH_R0, req.sda_in, cfg);
          default: begin
            base.shift_reg = {{(BYTE_W-1){1'b0}}, req.ack_level};
            res.st = enter_step(base, PH_A0, req.sda_in, cfg);
          end
        endcase
      end
    end else if (st.wait_count != '0) begin
      res.st.wait_count = st.wait_count - 1'b1;
    end else if (nx == PH_IDLE) begin
      res.st.phase = PH_IDLE;
      res.done     = 1'b1;
      if (st.current_op == OP_READ) begin
        res.st.rx_byte = st.shift_reg;
        res.st.sda_dir = 1'b1;
      end
    end else begin
      res.st = enter_step(st, nx, req.sda_in, cfg);
    end
  end

endmodule

// ===== design/bitbang_i2c_master.sv =====
// Top level of the tick-driven I2C bit-bang master: request register, sequencer, result register.
//
//   channel  direction  handshake             payload
//   in_      request    in_valid / in_ready   cmd_valid, op, wr_data, ack_level, sda_in
//   out_     result     out_valid / out_ready scl_out, sda_out, sda_drive, busy_res,
//                                             done_res, rx_data
//   cfg_     write      cfg_we                cfg_index, cfg_wdata
//
// Each request is one tick and yields one result; a new request is taken every cycle
// unless a held result stalls the request register. A request is registered first, then
// passes through the sequencer into the result register. Synchronous reset restores the
// default delays and an idle bus. When out_ready is low the result register holds and
// the request register fills, after which in_ready drops until the result is taken.
module bitbang_i2c_master
  import i2cbb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd_valid,
  input  logic [OP_W-1:0]   in_op,
  input  logic [BYTE_W-1:0] in_wr_data,
  input  logic              in_ack_level,
  input  logic              in_sda_in,

  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_scl_out,
  output logic              out_sda_out,
  output logic              out_sda_drive,
  output logic              out_busy_res,
  output logic              out_done_res,
  output logic [BYTE_W-1:0] out_rx_data,

  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [DLY_W-1:0]  cfg_wdata
);

  cfg_t  cfg_r;
  req_t  req_r;
  logic  req_valid_r;
  mach_t st_r;
  step_t step;
  logic  out_valid_r;
  logic  out_done_r;
  logic  out_adv;
  logic  req_adv;

  assign out_adv  = !out_valid_r || out_ready;
  assign req_adv  = req_valid_r && out_adv;
  assign in_ready = !req_valid_r || out_adv;

  i2cbb_step u_step (
    .st  (st_r),
    .req (req_r),
    .cfg (cfg_r),
    .res (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dly_short  <= RST_SHORT;
      cfg_r.dly_medium <= RST_MEDIUM;
      cfg_r.dly_setup  <= RST_SETUP;
      cfg_r.dly_long   <= RST_LONG;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHORT:  cfg_r.dly_short  <= cfg_wdata;
        CFG_MEDIUM: cfg_r.dly_medium <= cfg_wdata;
        CFG_SETUP:  cfg_r.dly_setup  <= cfg_wdata;
        CFG_LONG:   cfg_r.dly_long   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.cmd_valid <= in_cmd_valid;
      req_r.op        <= in_op;
      req_r.wr_data   <= in_wr_data;
      req_r.ack_level <= in_ack_level;
      req_r.sda_in    <= in_sda_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      req_valid_r <= 1'b1;
    end else if (req_adv) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_IDLE;
      st_r.wait_count <= '0;
      st_r.bit_count  <= '0;
      st_r.shift_reg  <= '0;
      st_r.current_op <= OP_START;
      st_r.scl_level  <= 1'b1;
      st_r.sda_level  <= 1'b1;
      st_r.sda_dir    <= 1'b1;
      st_r.rx_byte    <= '0;
    end else if (req_adv) begin
      st_r <= step.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_adv) begin
      out_done_r <= step.done;
    end
  end

  // The pin levels, busy flag and received byte are read straight from the bus state,
  // which only moves when a result is loaded.
  assign out_valid     = out_valid_r;
  assign out_scl_out   = st_r.scl_level;
  assign out_sda_out   = st_r.sda_level;
  assign out_sda_drive = st_r.sda_dir;
  assign out_busy_res  = (st_r.phase != PH_IDLE);
  assign out_done_res  = out_done_r;
  assign out_rx_data   = st_r.rx_byte;

endmodule
